FILE: sv/xtd_pkg.sv
// shared types and constants for the x-tiled framebuffer detiler
package xtd_pkg;

	// configuration register widths and reset values
	localparam int CFG_SIZE_W  = 14;
	localparam int PITCH_W     = 8;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 14;

	localparam logic [CFG_SIZE_W-1:0] FRAME_WIDTH_RST  = 14'd1920;
	localparam logic [CFG_SIZE_W-1:0] FRAME_HEIGHT_RST = 14'd1080;
	localparam logic [PITCH_W-1:0]    PITCH_TILES_RST  = 8'd15;

	// default frame size limits
	localparam int MAX_WIDTH_DEF  = 8192;
	localparam int MAX_HEIGHT_DEF = 8192;

	// tile geometry, as log2 of the sizes
	localparam int TILE_LG      = 12; // bytes per tile
	localparam int TILE_ROW_LG  = 9;  // bytes per tile row
	localparam int TILE_COLS_LG = 7;  // pixels across a tile
	localparam int TILE_ROWS_LG = 3;  // rows in a tile
	localparam int PIXEL_LG     = 2;  // bytes per pixel

	localparam int ADDR_W     = 29;
	localparam int PIX_W      = 32;
	localparam int CHAN_W     = 8;
	localparam int M_FIELDS_W = ADDR_W + 3 * CHAN_W;
	localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_PIXEL = 1'b1
	} xtd_cmd_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_PITCH_TILES  = 2'd2
	} xtd_reg_t;

	typedef struct packed {
		logic [ADDR_W-1:0] fetch_address;
		logic              pixel_valid;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic              frame_last;
	} xtd_result_t;

endpackage

FILE: sv/xtd_tile_addr.sv
// x-tiled byte address of a pixel from its column, row and pitch
module xtd_tile_addr import xtd_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic [$clog2(MAX_WIDTH)-1:0]  x,
	input  logic [$clog2(MAX_HEIGHT)-1:0] y,
	input  logic [PITCH_W-1:0]            pitch,
	output logic [ADDR_W-1:0]             addr
);

	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int BW = RW + PITCH_W;

	logic [BW-1:0] band;

	// start of the tile row band: (y/8) * pitch tiles
	assign band = BW'(y >> TILE_ROWS_LG) * BW'(pitch);

	assign addr = (ADDR_W'(band) << TILE_LG)
		+ (ADDR_W'(x >> TILE_COLS_LG) << TILE_LG)
		+ (ADDR_W'(y[TILE_ROWS_LG-1:0]) << TILE_ROW_LG)
		+ (ADDR_W'(x[TILE_COLS_LG-1:0]) << PIXEL_LG);

endmodule

FILE: sv/xtd_walker.sv
// raster counters, frame state and result assembly
module xtd_walker import xtd_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  xtd_cmd_t              cmd,
	input  logic [PIX_W-1:0]      word,
	input  logic [CFG_SIZE_W-1:0] frame_width,
	input  logic [CFG_SIZE_W-1:0] frame_height,
	input  logic [PITCH_W-1:0]    pitch_tiles,
	output xtd_result_t           res
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int WSZ = (CW + 1 > CFG_SIZE_W) ? CW + 1 : CFG_SIZE_W;
	localparam int HSZ = (RW + 1 > CFG_SIZE_W) ? RW + 1 : CFG_SIZE_W;

	logic [CW-1:0]     col_q, col_d;
	logic [RW-1:0]     row_q, row_d;
	logic              active_q, active_d;
	logic [WSZ-1:0]    w_eff, col_inc;
	logic [HSZ-1:0]    h_eff, row_inc;
	logic              col_wrap, row_wrap;
	logic [ADDR_W-1:0] next_addr;

	xtd_tile_addr #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_addr (
		.x    (col_d),
		.y    (row_d),
		.pitch(pitch_tiles),
		.addr (next_addr)
	);

	always_comb begin
		// zero reads as one, oversize saturates
		if (frame_width == '0) begin
			w_eff = WSZ'(1);
		end else if (WSZ'(frame_width) > WSZ'(MAX_WIDTH)) begin
			w_eff = WSZ'(MAX_WIDTH);
		end else begin
			w_eff = WSZ'(frame_width);
		end
		if (frame_height == '0) begin
			h_eff = HSZ'(1);
		end else if (HSZ'(frame_height) > HSZ'(MAX_HEIGHT)) begin
			h_eff = HSZ'(MAX_HEIGHT);
		end else begin
			h_eff = HSZ'(frame_height);
		end
		col_inc  = WSZ'(col_q) + WSZ'(1);
		row_inc  = HSZ'(row_q) + HSZ'(1);
		col_wrap = col_inc >= w_eff;
		row_wrap = row_inc >= h_eff;

		col_d    = col_q;
		row_d    = row_q;
		active_d = active_q;
		res      = '0;
		case (cmd)
			CMD_START: begin
				col_d             = '0;
				row_d             = '0;
				active_d          = 1'b1;
				res.fetch_address = next_addr;
			end
			CMD_PIXEL: begin
				if (active_q) begin
					res.pixel_valid = 1'b1;
					res.red         = word[23:16];
					res.green       = word[15:8];
					res.blue        = word[7:0];
					if (col_wrap) begin
						col_d = '0;
						if (row_wrap) begin
							row_d          = '0;
							active_d       = 1'b0;
							res.frame_last = 1'b1;
						end else begin
							row_d = RW'(row_inc);
						end
					end else begin
						col_d = CW'(col_inc);
					end
					// counters are back at zero after the final pixel, so this is zero then
					res.fetch_address = next_addr;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			active_q <= 1'b0;
		end else if (en) begin
			col_q    <= col_d;
			row_q    <= row_d;
			active_q <= active_d;
		end
	end

endmodule

FILE: sv/x_tiled_framebuffer_detiler.sv
// top level of the x-tiled framebuffer detiler
//
// walks a frame in raster order over an x-tiled buffer of 4 kb tiles (8 rows of
// 512 bytes, 32-bit xrgb pixels) and converts the fetched pixel words
// input stream: s_tuser is the command (0 starts a frame, 1 carries a pixel
//   word), s_tdata the fetched xrgb word
// output stream: one beat per input beat; m_tdata fields red, green, blue
//   (swapped from the b,g,r memory order), the tiled byte address of the next
//   raster pixel, m_tuser flags a converted pixel and m_tlast marks the final
//   pixel of the frame, whose address is zero
// a start beat returns the address of pixel (0,0); pixel words while no frame
//   is open give an all-zero beat
// flow: a beat that is taken sits in the input register, and its result is
//   loaded into the output register once that register is free or emptying,
//   so it shows on m_* from the output register
// throughput: one beat per cycle unless the output side stalls; the counter update,
//   the one pitch multiply of the address and the byte swap all fit between the two registers
// stalls: while the output register is full and m_tready is low it holds, the input register
//   still takes a beat if it is empty, and s_tready drops only when both are full
// reset: counters clear, no frame is open, size and pitch registers return to 1920 x
//   1080 and 15 tiles; the user has the cfg port write them while idle (not enforced)
module x_tiled_framebuffer_detiler import xtd_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration writes
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	// input stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [PIX_W-1:0]       s_tdata,  // pixel_word[31:0]
	input  logic                   s_tuser,  // cmd
	// output stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [M_TDATA_W-1:0]   m_tdata,  // fetch_address[28:0], red, green, blue, zero pad
	output logic                   m_tuser,  // pixel_valid
	output logic                   m_tlast   // frame_last
);

	logic [CFG_SIZE_W-1:0] frame_width_q;
	logic [CFG_SIZE_W-1:0] frame_height_q;
	logic [PITCH_W-1:0]    pitch_tiles_q;

	// input register
	logic                  v_s1;
	xtd_cmd_t              cmd_s1;
	logic [PIX_W-1:0]      word_s1;

	// output register
	logic                  v_s2;
	xtd_result_t           res_s2;

	xtd_result_t           res;
	logic                  adv;

	// register writes, indices past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
			pitch_tiles_q  <= PITCH_TILES_RST;
		end else if (cfg_we) begin
			case (xtd_reg_t'(cfg_index))
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[CFG_SIZE_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[CFG_SIZE_W-1:0];
				REG_PITCH_TILES:  pitch_tiles_q  <= cfg_data[PITCH_W-1:0];
				default: ;
			endcase
		end
	end

	// the input register moves on whenever the output register is free or emptying
	assign adv      = !v_s2 || m_tready;
	assign s_tready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				v_s1 <= s_tvalid;
			end
			if (adv) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1  <= xtd_cmd_t'(s_tuser);
			word_s1 <= s_tdata;
		end
		if (adv && v_s1) begin
			res_s2 <= res;
		end
	end

	// frame state steps once per beat that leaves the input register
	xtd_walker #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_walker (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (adv && v_s1),
		.cmd         (cmd_s1),
		.word        (word_s1),
		.frame_width (frame_width_q),
		.frame_height(frame_height_q),
		.pitch_tiles (pitch_tiles_q),
		.res         (res)
	);

	assign m_tvalid = v_s2;
	assign m_tdata  = {(M_TDATA_W - M_FIELDS_W)'(0), res_s2.blue, res_s2.green,
		res_s2.red, res_s2.fetch_address};
	assign m_tuser  = res_s2.pixel_valid;
	assign m_tlast  = res_s2.frame_last;

`ifndef ASSERT_OFF
	// the final pixel is always a converted pixel and points back to zero
	a_last_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser && res_s2.fetch_address == '0)
		else $error("frame end beat without a pixel or with a non-zero address");

	// beats without a pixel carry no colour and never close a frame
	a_empty_beat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> res_s2.red == '0 && res_s2.green == '0
			&& res_s2.blue == '0 && !m_tlast)
		else $error("beat without a pixel carries colour or frame end");

	// the input side only stalls when the output register is full and held
	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled while the output side could move");

	// a start beat must leave the address of pixel zero
	a_start_addr: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_s1 && cmd_s1 == CMD_START |=> m_tvalid && !m_tuser
			&& res_s2.fetch_address == '0)
		else $error("start beat did not give address zero");
`endif

endmodule
